### sv/hbe_pkg.sv
// Package with the types and codes shared by the histogram bin engine.
`default_nettype none

package hbe_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int INDEX_WIDTH = 6;
    localparam int CODE_WIDTH  = 6;
    localparam int NB_WIDTH    = 7;
    localparam int CFG_IDX_WIDTH = 2;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_MISS_SKIP = 2'd2;
    localparam logic [1:0] STAT_MISS_ERR  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_NUM_BREAKS    = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RIGHT_CLOSED  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEEP_BORDER   = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ALLOW_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]                    op;
        logic [INDEX_WIDTH-1:0]        index;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          is_missing;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [CODE_WIDTH-1:0]  bin_code;
        logic [COUNT_WIDTH-1:0] bin_count;
    } out_item_t;

    typedef struct packed {
        logic [NB_WIDTH-1:0] num_breaks;
        logic                right_closed;
        logic                keep_border;
        logic                allow_missing;
    } cfg_t;

    typedef enum logic [2:0] {
        CMD_LOAD,
        CMD_SAMPLE,
        CMD_MISSING,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                     kind;
        logic [INDEX_WIDTH-1:0]        addr;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LO,
        BK_HI,
        BK_MID,
        BK_CNT,
        BK_RDCNT
    } back_state_t;

endpackage

`default_nettype wire

### sv/hbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hbe_ram #(
    parameter int WIDTH      = 32,
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [ADDR_WIDTH-1:0] waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_WIDTH-1:0] raddr,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/hbe_front.sv
// Front end: decodes input transactions into commands and queues them.
`default_nettype none

module hbe_front import hbe_pkg::*; #(
    parameter int MAX_BREAKS = 64
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          cmd_valid,
    input  wire logic     cmd_pop,
    output cmd_t          cmd
);

    localparam int DEPTH = 2;

    cmd_t        entry_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    cmd_t        cmd_in;
    logic [31:0] index_wide;
    logic        push;

    assign index_wide = 32'(s_data.index);

    // Classify the incoming transaction.
    always_comb begin
        cmd_in.addr     = s_data.index;
        cmd_in.value    = s_data.value;
        cmd_in.in_range = 1'b0;
        case (s_data.op)
            OP_LOAD: begin
                cmd_in.kind     = CMD_LOAD;
                cmd_in.in_range = index_wide < MAX_BREAKS;
            end
            OP_SAMPLE: begin
                cmd_in.kind = s_data.is_missing ? CMD_MISSING : CMD_SAMPLE;
            end
            OP_READ: begin
                cmd_in.kind     = CMD_READ;
                cmd_in.in_range = index_wide < (MAX_BREAKS - 1);
            end
            OP_CLEAR: begin
                cmd_in.kind = CMD_CLEAR;
            end
            default: begin
                cmd_in.kind = CMD_CLEAR;
            end
        endcase
    end

    assign s_ready   = count_reg != 2'(DEPTH);
    assign push      = s_valid && s_ready;
    assign cmd_valid = count_reg != 2'd0;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

### sv/hbe_back.sv
// Back end: executes queued commands against the break table and bin counts.
`default_nettype none

module hbe_back import hbe_pkg::*; #(
    parameter int MAX_BREAKS = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    input  wire cmd_t cmd,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_data
);

    localparam int NUM_BINS = MAX_BREAKS - 1;
    localparam int AW       = $clog2(MAX_BREAKS);
    localparam int AW1      = AW + 1;
    localparam int BW       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    back_state_t state_reg, state_next;

    logic signed [VALUE_WIDTH-1:0] x_reg, x_next;
    logic signed [VALUE_WIDTH-1:0] blo_reg, blo_next;
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    logic                vld_rd_reg, vld_rd_next;
    logic [NUM_BINS-1:0] cnt_vld_reg, cnt_vld_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    logic                brk_we, brk_re;
    logic [AW-1:0]       brk_waddr, brk_raddr;
    logic [VALUE_WIDTH-1:0] brk_wdata, brk_rdata;
    logic signed [VALUE_WIDTH-1:0] brk_val;
    logic                cnt_we, cnt_re;
    logic [BW-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata, cnt_cur, cnt_new;

    logic [31:0]   addr_wide, nb_wide, code_wide;
    logic [AW1-1:0] mid_sum, mid_sum_n;
    logic [AW-1:0] mid_cur, mid_n, hi_init;
    logic          out_free, lft, out_range, go_right, narrow;

    hbe_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_BREAKS)) u_break_ram (
        .aclk  (aclk),
        .we    (brk_we),
        .waddr (brk_waddr),
        .wdata (brk_wdata),
        .re    (brk_re),
        .raddr (brk_raddr),
        .rdata (brk_rdata)
    );

    hbe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign brk_val   = $signed(brk_rdata);
    assign addr_wide = 32'(cmd.addr);
    assign lft       = !cfg.right_closed;
    assign out_free  = !out_valid_reg || m_ready;

    // Clamp the break count to [2, MAX_BREAKS].
    always_comb begin
        if (cfg.num_breaks < NB_WIDTH'(2)) begin
            nb_wide = 32'd2;
        end else if (32'(cfg.num_breaks) > MAX_BREAKS) begin
            nb_wide = 32'(MAX_BREAKS);
        end else begin
            nb_wide = 32'(cfg.num_breaks);
        end
    end

    assign hi_init = nb_wide[AW-1:0] - AW'(1);
    assign mid_sum = AW1'(lo_reg) + AW1'(hi_reg);
    assign mid_cur = mid_sum[AW:1];

    // Saturating count update for the bin at lo.
    assign cnt_cur   = vld_rd_reg ? cnt_rdata : '0;
    assign cnt_new   = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
    assign code_wide = 32'(lo_reg) + 32'd1;

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        blo_next       = blo_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        vld_rd_next    = vld_rd_reg;
        cnt_vld_next   = cnt_vld_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        brk_we         = 1'b0;
        brk_waddr      = addr_wide[AW-1:0];
        brk_wdata      = cmd.value;
        brk_re         = 1'b0;
        brk_raddr      = lo_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = lo_reg[BW-1:0];
        cnt_wdata      = cnt_new;
        cnt_re         = 1'b0;
        cnt_raddr      = lo_reg[BW-1:0];
        out_range      = 1'b0;
        go_right       = 1'b0;
        narrow         = 1'b0;
        mid_sum_n      = '0;
        mid_n          = '0;

        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    out_data_next = '{status: STAT_OK, bin_code: '0, bin_count: '0};
                    case (cmd.kind)
                        CMD_LOAD: begin
                            brk_we         = cmd.in_range;
                            out_valid_next = 1'b1;
                        end
                        CMD_SAMPLE: begin
                            x_next     = cmd.value;
                            lo_next    = '0;
                            hi_next    = hi_init;
                            brk_re     = 1'b1;
                            brk_raddr  = '0;
                            state_next = BK_LO;
                        end
                        CMD_MISSING: begin
                            out_data_next.status = cfg.allow_missing ? STAT_MISS_SKIP
                                                                     : STAT_MISS_ERR;
                            out_valid_next = 1'b1;
                        end
                        CMD_READ: begin
                            if (cmd.in_range) begin
                                cnt_re      = 1'b1;
                                cnt_raddr   = addr_wide[BW-1:0];
                                vld_rd_next = cnt_vld_reg[addr_wide[BW-1:0]];
                                state_next  = BK_RDCNT;
                            end else begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            cnt_vld_next   = '0;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            BK_LO: begin
                blo_next   = brk_val;
                brk_re     = 1'b1;
                brk_raddr  = hi_reg;
                state_next = BK_HI;
            end

            BK_HI: begin
                // brk_val holds the top break here.
                out_range = (x_reg < blo_reg) || (brk_val < x_reg) ||
                            (!cfg.keep_border &&
                             (x_reg == (lft ? brk_val : blo_reg)));
                narrow = (AW1'(hi_reg) - AW1'(lo_reg)) < AW1'(2);
                if (out_range) begin
                    out_data_next  = '{status: STAT_RANGE, bin_code: '0, bin_count: '0};
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end else if (narrow) begin
                    cnt_re      = 1'b1;
                    vld_rd_next = cnt_vld_reg[lo_reg[BW-1:0]];
                    state_next  = BK_CNT;
                end else begin
                    brk_re     = 1'b1;
                    brk_raddr  = mid_cur;
                    state_next = BK_MID;
                end
            end

            BK_MID: begin
                // One halving step: brk_val is the break at the midpoint.
                go_right = (x_reg > brk_val) || (lft && (x_reg == brk_val));
                if (go_right) begin
                    lo_next = mid_cur;
                end else begin
                    hi_next = mid_cur;
                end
                narrow    = (AW1'(hi_next) - AW1'(lo_next)) < AW1'(2);
                mid_sum_n = AW1'(lo_next) + AW1'(hi_next);
                mid_n     = mid_sum_n[AW:1];
                if (narrow) begin
                    cnt_re      = 1'b1;
                    cnt_raddr   = lo_next[BW-1:0];
                    vld_rd_next = cnt_vld_reg[lo_next[BW-1:0]];
                    state_next  = BK_CNT;
                end else begin
                    brk_re    = 1'b1;
                    brk_raddr = mid_n;
                end
            end

            BK_CNT: begin
                cnt_we = 1'b1;
                cnt_vld_next[lo_reg[BW-1:0]] = 1'b1;
                out_data_next = '{status: STAT_OK, bin_code: code_wide[CODE_WIDTH-1:0],
                                  bin_count: cnt_new};
                out_valid_next = 1'b1;
                state_next     = BK_IDLE;
            end

            BK_RDCNT: begin
                out_data_next  = '{status: STAT_OK, bin_code: '0, bin_count: cnt_cur};
                out_valid_next = 1'b1;
                state_next     = BK_IDLE;
            end

            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_vld_reg   <= cnt_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        blo_reg      <= blo_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        vld_rd_reg   <= vld_rd_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

### sv/histogram_bin_engine.sv
// Top level of the histogram bin engine: configuration registers, front end and back end.
//
// The engine keeps a table of up to MAX_BREAKS ascending signed break points and a
// saturating 32-bit count for each of the bins between them. Each input transaction
// carries an op: load a break point into the table, classify a sample (binary search
// into right-closed (a,b] or left-closed [a,b) bins, bump that bin's count and return
// the 1-based bin code with the new count), read a bin count, or clear all counts.
// Every input transaction gives exactly one result transaction with a status: ok, out
// of range, missing skipped, or missing error. Counts are cleared at reset and by the
// clear op; break points are undefined until loaded, and samples must only
// be classified against loaded breaks. Configuration is written through
// cfg_we/cfg_index/cfg_wdata, and only while the engine is idle; the user must keep
// to this, as the block itself does not enforce it. A front end decodes transactions
// into a two-entry command queue, so up to two transactions are taken while the back
// end is busy and a finished result waits in the output register. The back end takes
// one command at a time: load, clear, missing-sample and out-of-table reads finish in
// the idle state, count reads go on through BK_RDCNT, and a sample reads the end
// breaks in BK_LO and BK_HI, stops there when out of range, else runs halving steps
// in BK_MID until the interval is narrow and updates its count in BK_CNT. The single
// read port of the break-table RAM sets the sample time: the two end breaks and each
// halving step need a read each, followed by one read-modify-write of the count RAM.
`default_nettype none

module histogram_bin_engine import hbe_pkg::*; #(
    parameter int MAX_BREAKS = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [NB_WIDTH-1:0]      cfg_wdata,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire in_item_t                 s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_item_t                     m_data
);

    logic [NB_WIDTH-1:0] num_breaks_reg;
    logic                right_closed_reg;
    logic                keep_border_reg;
    logic                allow_missing_reg;
    cfg_t                cfg;
    logic                cmd_valid;
    logic                cmd_pop;
    cmd_t                cmd;

    // Configuration registers. Writes take effect at once; the user only writes them
    // while no transaction is in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_breaks_reg    <= NB_WIDTH'(2);
            right_closed_reg  <= 1'b1;
            keep_border_reg   <= 1'b0;
            allow_missing_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NUM_BREAKS:    num_breaks_reg    <= cfg_wdata;
                CFG_RIGHT_CLOSED:  right_closed_reg  <= cfg_wdata[0];
                CFG_KEEP_BORDER:   keep_border_reg   <= cfg_wdata[0];
                CFG_ALLOW_MISSING: allow_missing_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = '{num_breaks:    num_breaks_reg,
                   right_closed:  right_closed_reg,
                   keep_border:   keep_border_reg,
                   allow_missing: allow_missing_reg};

    // The front end decodes each input transaction and queues it as a command.
    hbe_front #(.MAX_BREAKS(MAX_BREAKS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // The back end runs the search and count updates and owns the output register.
    hbe_back #(.MAX_BREAKS(MAX_BREAKS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### tb/hbe_bin_checker.sv
// Checker that predicts the histogram bin engine's results and compares them on the result channel.
`timescale 1ns / 1ps

module hbe_bin_checker import hbe_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [NB_WIDTH-1:0]      cfg_wdata,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire in_item_t                 s_data,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire out_item_t                m_data,
    output int                            fail_count,
    output int                            pending,
    output int                            results_seen
);

    localparam int TABLE_DEPTH = 64;
    localparam int BIN_SLOTS   = TABLE_DEPTH - 1;

    logic signed [VALUE_WIDTH-1:0] break_pts [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]        bin_tally [BIN_SLOTS];
    cfg_t                          setting;
    out_item_t                     awaited_results [$];

    // Works out the result of one transaction and updates the mirrored table and counts.
    function automatic out_item_t bin_lookup_result(in_item_t it);
        out_item_t                     r;
        logic signed [VALUE_WIDTH-1:0] x;
        logic signed [VALUE_WIDTH-1:0] border;
        logic                          left_closed;
        int                            nb;
        int                            lo;
        int                            hi;
        int                            mid;
        r = '0;
        x = it.value;
        left_closed = !setting.right_closed;
        case (it.op)
            OP_LOAD: begin
                break_pts[it.index] = x;
            end
            OP_SAMPLE: begin
                if (it.is_missing) begin
                    r.status = setting.allow_missing ? STAT_MISS_SKIP : STAT_MISS_ERR;
                end else begin
                    nb = setting.num_breaks;
                    if (nb < 2) nb = 2;
                    if (nb > TABLE_DEPTH) nb = TABLE_DEPTH;
                    lo = 0;
                    hi = nb - 1;
                    border = left_closed ? break_pts[hi] : break_pts[lo];
                    if (x < break_pts[lo] || x > break_pts[hi] ||
                        (x == border && !setting.keep_border)) begin
                        r.status = STAT_RANGE;
                    end else begin
                        while (hi - lo >= 2) begin
                            mid = (hi + lo) / 2;
                            if (x > break_pts[mid] || (left_closed && x == break_pts[mid]))
                                lo = mid;
                            else
                                hi = mid;
                        end
                        if (bin_tally[lo] != '1) bin_tally[lo] = bin_tally[lo] + 1'b1;
                        r.status    = STAT_OK;
                        r.bin_code  = CODE_WIDTH'(lo + 1);
                        r.bin_count = bin_tally[lo];
                    end
                end
            end
            OP_READ: begin
                if (it.index < BIN_SLOTS) r.bin_count = bin_tally[it.index];
            end
            OP_CLEAR: begin
                for (int i = 0; i < BIN_SLOTS; i++) bin_tally[i] = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        int        errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) break_pts[i] = '0;
            for (int i = 0; i < BIN_SLOTS; i++) bin_tally[i] = '0;
            setting = '{num_breaks: 7'd2, right_closed: 1'b1, keep_border: 1'b0,
                        allow_missing: 1'b1};
            awaited_results.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NUM_BREAKS:    setting.num_breaks    = cfg_wdata;
                    CFG_RIGHT_CLOSED:  setting.right_closed  = cfg_wdata[0];
                    CFG_KEEP_BORDER:   setting.keep_border   = cfg_wdata[0];
                    CFG_ALLOW_MISSING: setting.allow_missing = cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) awaited_results.push_back(bin_lookup_result(s_data));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0) begin
                    $error("result transaction with nothing awaited: status %0d code %0d count %0d",
                           m_data.status, m_data.bin_code, m_data.bin_count);
                    errs++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_data.status);
                        errs++;
                    end
                    if (m_data.bin_code !== want.bin_code) begin
                        $error("bin_code mismatch: expected %0d, actual %0d",
                               want.bin_code, m_data.bin_code);
                        errs++;
                    end
                    if (m_data.bin_count !== want.bin_count) begin
                        $error("bin_count mismatch: expected %0d, actual %0d",
                               want.bin_count, m_data.bin_count);
                        errs++;
                    end
                end
            end
            pending <= awaited_results.size();
        end
        fail_count <= fail_count + errs;
    end

endmodule

### tb/histogram_bin_engine_tb.sv
// Top of the histogram bin engine testbench: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module histogram_bin_engine_tb;
    import hbe_pkg::*;

    // The run stops offering new phases once this many transactions have been sent.
    localparam int ITEM_TARGET = 900;
    // Cycles in a row without any accepted transaction before the run is declared hung.
    // The slowest legal stretch is the long receiver hold plus a sender gap and one sample.
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_PER_PHASE = 50;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [NB_WIDTH-1:0]      cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    in_item_t                 s_data;
    logic                     m_valid;
    logic                     m_ready;
    out_item_t                m_data;

    int fail_count;
    int pending;
    int results_seen;

    // Stimulus-side copy of the loaded break points. It only steers sample values toward
    // the borders and reloads near existing breaks; all prediction lives in the checker.
    logic signed [VALUE_WIDTH-1:0] shadow_pts [64];
    int eff_breaks;

    // When set, the sender offers back to back for the whole phase.
    bit burst_mode;
    // The sender raises hold_req once; the receiver then withholds ready for a long hold set by LONG_HOLD.
    bit hold_req;
    bit hold_done;

    int n_sent, n_load, n_sample, n_read, n_clear, n_phase;
    int idle_cycles;

    histogram_bin_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    hbe_bin_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic in_item_t make_item(logic [1:0] op, logic [INDEX_WIDTH-1:0] idx,
                                           logic [VALUE_WIDTH-1:0] v, logic miss);
        in_item_t it;
        it.op         = op;
        it.index      = idx;
        it.value      = v;
        it.is_missing = miss;
        return it;
    endfunction

    // Offers one transaction and holds it until the engine takes it, then idles for a
    // random gap: mostly none, sometimes a short pause, now and then a long pause.
    // The ready sampled right after the edge is the value the edge itself saw.
    task automatic offer(in_item_t it);
        int r;
        int gap;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        case (it.op)
            OP_LOAD: begin
                n_load++;
                shadow_pts[it.index] = it.value;
            end
            OP_SAMPLE: n_sample++;
            OP_READ:   n_read++;
            OP_CLEAR:  n_clear++;
            default: begin
            end
        endcase
        r = $urandom_range(0, 99);
        if (burst_mode || r < 70) gap = 0;
        else if (r < 93) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every awaited result has come back. The first edge
    // lets the checker count a transaction that was accepted at the edge just passed.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [NB_WIDTH-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    // Registers are only written with the engine idle, so every setting change drains first.
    task automatic apply_setting(logic [NB_WIDTH-1:0] nb, logic rc, logic ib, logic am);
        drain();
        write_reg(CFG_NUM_BREAKS, nb);
        write_reg(CFG_RIGHT_CLOSED, {6'd0, rc});
        write_reg(CFG_KEEP_BORDER, {6'd0, ib});
        write_reg(CFG_ALLOW_MISSING, {6'd0, am});
        cfg_we <= 1'b0;
        // Below two the engine uses two break points, above 64 it uses 64.
        eff_breaks = (nb < 2) ? 2 : (nb > 64) ? 64 : nb;
    endtask

    // Loads every active break point so no sample ever looks at an unwritten entry.
    // Tables are dense with ties, moderately spread, spread over the full signed range,
    // or (rarely) unsorted noise.
    task automatic load_table();
        int     mode;
        longint acc;
        mode = $urandom_range(0, 7);
        acc  = $signed($urandom);
        if (mode == 1) acc = longint'($urandom_range(0, 1000)) - 500;
        for (int i = 0; i < eff_breaks; i++) begin
            case (mode)
                0, 4: acc = acc + $urandom_range(0, 3);
                1, 5: acc = acc + $urandom_range(1, 100000);
                2, 6: acc = -64'sd2147483648 + (longint'(i) * 64'sd4294967295) / (eff_breaks - 1);
                3:    acc = $signed($urandom);
                default: acc = acc + $urandom_range(0, 4000);
            endcase
            offer(make_item(OP_LOAD, INDEX_WIDTH'(i), acc[31:0], 1'($urandom_range(0, 1))));
        end
    endtask

    // Sample values are mostly placed on, just above or just below a break point, so
    // that both sides of every border and both closure rules get exercised.
    task automatic send_sample();
        int                            k;
        logic signed [VALUE_WIDTH-1:0] v;
        logic                          miss;
        k = $urandom_range(0, eff_breaks - 1);
        case ($urandom_range(0, 9))
            0, 1, 2: v = shadow_pts[k];
            3, 4:    v = shadow_pts[k] + 1;
            5:       v = shadow_pts[k] - 1;
            6:       v = $urandom;
            7:       v = VAL_MIN;
            8:       v = VAL_MAX;
            default: v = shadow_pts[k] + $signed($urandom_range(0, 255)) - 128;
        endcase
        miss = ($urandom_range(0, 7) == 0);
        offer(make_item(OP_SAMPLE, INDEX_WIDTH'($urandom_range(0, 63)), v, miss));
    endtask

    task automatic random_item();
        int                     r;
        logic [INDEX_WIDTH-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 66) begin
            send_sample();
        end else if (r < 84) begin
            // Half the reads hit active bins, the rest can land on stale or absent bins.
            if ($urandom_range(0, 1)) idx = INDEX_WIDTH'($urandom_range(0, eff_breaks - 2));
            else idx = INDEX_WIDTH'($urandom_range(0, 63));
            offer(make_item(OP_READ, idx, $urandom, 1'($urandom_range(0, 1))));
        end else if (r < 97) begin
            // Half the reloads nudge an existing break, which may leave the table unsorted.
            idx = INDEX_WIDTH'($urandom_range(0, 63));
            offer(make_item(OP_LOAD, idx,
                            $urandom_range(0, 1) ? $urandom
                                                 : shadow_pts[idx] + $urandom_range(0, 8) - 4,
                            1'($urandom_range(0, 1))));
        end else begin
            offer(make_item(OP_CLEAR, INDEX_WIDTH'($urandom), $urandom,
                            1'($urandom_range(0, 1))));
        end
    endtask

    // Receiver: ready drops for random stretches, mostly short, now and then long, with
    // runs of steady ready in between. Once the sender asks for it, ready is held low for
    // a long stretch so the engine's queue fills and it stops taking transactions.
    initial begin : result_side
        int r;
        int n;
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 60) n = 0;
            else if (r < 90) n = $urandom_range(1, 4);
            else n = $urandom_range(15, 50);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // Watchdog: the run is hung if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int nb_list [12];
        int nb;
        nb_list = '{1, 2, 3, 127, 64, 5, 33, 9, 64, 17, 0, 100};
        for (int i = 0; i < 64; i++) shadow_pts[i] = '0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_NUM_BREAKS;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        eff_breaks = 2;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset setting: right-closed bins, border excluded,
        // missing samples skipped. The table spans the whole signed range.
        offer(make_item(OP_LOAD, 6'd0, VAL_MIN, 1'b0));
        offer(make_item(OP_LOAD, 6'd1, VAL_MAX, 1'b1));
        offer(make_item(OP_SAMPLE, 6'd0, VAL_MIN, 1'b0));   // open lower border, out of range
        offer(make_item(OP_SAMPLE, 6'd0, VAL_MAX, 1'b0));   // closed upper border, bin 1
        offer(make_item(OP_SAMPLE, 6'd63, 32'sd0, 1'b0));
        offer(make_item(OP_SAMPLE, 6'd0, -32'sd1, 1'b0));
        offer(make_item(OP_SAMPLE, 6'd0, 32'sd5, 1'b1));     // missing, skipped quietly
        offer(make_item(OP_READ, 6'd0, 32'sd0, 1'b0));
        offer(make_item(OP_READ, 6'd62, 32'sd0, 1'b0));      // inactive bin
        offer(make_item(OP_READ, 6'd63, VAL_MAX, 1'b1));     // beyond the count store
        offer(make_item(OP_CLEAR, 6'd63, VAL_MIN, 1'b0));
        offer(make_item(OP_READ, 6'd0, 32'sd0, 1'b0));
        offer(make_item(OP_LOAD, 6'd63, 32'sh5A5A_A5A5, 1'b0));
        offer(make_item(OP_LOAD, 6'd1, 32'sd100, 1'b0));

        // A break count of zero acts as two; left-closed bins with the border included,
        // and missing samples reported as errors.
        apply_setting(7'd0, 1'b0, 1'b1, 1'b0);
        offer(make_item(OP_SAMPLE, 6'd0, 32'sd100, 1'b0));   // included upper border
        offer(make_item(OP_SAMPLE, 6'd0, VAL_MIN, 1'b0));    // closed lower border
        offer(make_item(OP_SAMPLE, 6'd0, 32'sd101, 1'b0));   // above the table
        offer(make_item(OP_SAMPLE, 6'd0, 32'sd7, 1'b1));     // missing, reported
        offer(make_item(OP_READ, 6'd0, 32'sd0, 1'b0));

        // Random phases: each one changes the setting with the engine idle, reloads the
        // active table, mostly as a sorted run, then mixes random transactions.
        while (n_sent < ITEM_TARGET) begin
            if (n_phase < 12) begin
                nb = nb_list[n_phase];
                apply_setting(NB_WIDTH'(nb), n_phase[0], n_phase[1], n_phase[2]);
            end else begin
                apply_setting(NB_WIDTH'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            burst_mode = (n_phase % 3 == 1);
            load_table();
            for (int j = 0; j < RAND_PER_PHASE; j++) begin
                if (n_phase == 2 && j == 5) hold_req = 1'b1;
                random_item();
            end
            n_phase++;
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("Covered %0d transactions in %0d settings plus the directed checks:",
                 n_sent, n_phase);
        $display("  %0d samples, %0d loads, %0d reads, %0d clears; %0d results compared.",
                 n_sample, n_load, n_read, n_clear, results_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
sv/hbe_pkg.sv
sv/hbe_ram.sv
sv/hbe_front.sv
sv/hbe_back.sv
sv/histogram_bin_engine.sv
tb/hbe_bin_checker.sv
tb/histogram_bin_engine_tb.sv
